// ===== src/hds_pkg.sv =====
package hds_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 20;

   localparam logic CSR_COEFF_ONE = 1'b0;
   localparam logic CSR_COEFF_TWO = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NONPOS = 2'd1;
   localparam logic [1:0] STATUS_SAT    = 2'd2;

endpackage

// ===== src/hyperelastic_deviatoric_stress.sv =====
// Channel | Direction | Handshake           | Beat
// req     | in        | req_valid/req_stall | b_xx..b_xz, inv_jacobian
// rsp     | out       | rsp_valid/rsp_stall | s_xx..s_xz, status
// csr     | in        | csr_wr_en           | csr_index, csr_wr_data
//
// One beat enters per cycle while the pipeline is not stalled.
// The cube root takes two stages per result bit, one rounded product each.
// Reset is synchronous, clears the valid bits and coefficient two, and sets coefficient one to 1 << FRAC_BITS.
// A stall on rsp while a response is valid holds every stage; req_stall follows it in the same cycle.
module hyperelastic_deviatoric_stress
   import hds_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_b_xx,
   input  logic [WORD_BITS-1:0] req_b_yy,
   input  logic [WORD_BITS-1:0] req_b_zz,
   input  logic [WORD_BITS-1:0] req_b_xy,
   input  logic [WORD_BITS-1:0] req_b_yz,
   input  logic [WORD_BITS-1:0] req_b_xz,
   input  logic [WORD_BITS-1:0] req_inv_jacobian,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_s_xx,
   output logic [WORD_BITS-1:0] rsp_s_yy,
   output logic [WORD_BITS-1:0] rsp_s_zz,
   output logic [WORD_BITS-1:0] rsp_s_xy,
   output logic [WORD_BITS-1:0] rsp_s_yz,
   output logic [WORD_BITS-1:0] rsp_s_xz,
   output logic [1:0]           rsp_status,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [WORD_BITS-1:0] csr_wr_data
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int CR = W - 1;
   localparam int CL = 2 * CR - 1;

   localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
   localparam logic [2*W:0] RND  = {{(2*W){1'b0}}, 1'b1} << (F - 1);
   localparam logic [2*W:0] HALF = {{(2*W){1'b0}}, 1'b1} << (W - 1);
   localparam logic [W-1:0] THIRD = W'(((64'd1 << F) + 64'd1) / 64'd3);
   localparam logic [W-2:0] C1_RESET = (W-1)'({{(W-1){1'b0}}, 1'b1} << F);

   localparam logic [2:0] PA [18] = '{3'd0, 3'd3, 3'd5, 3'd3, 3'd1, 3'd4, 3'd5, 3'd4, 3'd2,
                                       3'd0, 3'd3, 3'd5, 3'd3, 3'd1, 3'd4, 3'd0, 3'd3, 3'd5};
   localparam logic [2:0] PB [18] = '{3'd0, 3'd3, 3'd5, 3'd3, 3'd1, 3'd4, 3'd5, 3'd4, 3'd2,
                                       3'd3, 3'd1, 3'd4, 3'd5, 3'd4, 3'd2, 3'd5, 3'd4, 3'd2};

   typedef struct packed {
      logic [W-1:0]        c;
      logic [W-1:0]        t;
      logic [W-1:0]        sq;
      logic                sqsat;
      logic [W-1:0]        j;
      logic [5:0][W-1:0]   b;
   } cr_stage_type;

   function automatic logic [W:0] fmul(input logic [W-1:0] a, input logic [W-1:0] b);
      logic           neg;
      logic [W-1:0]   ua;
      logic [W-1:0]   ub;
      logic [2*W-1:0] p;
      logic [2*W:0]   q;
      logic [2*W:0]   lim;
      logic [W-1:0]   r;
      logic [W:0]     res;
      neg = a[W-1] ^ b[W-1];
      ua  = a[W-1] ? (~a + 1'b1) : a;
      ub  = b[W-1] ? (~b + 1'b1) : b;
      p   = {{W{1'b0}}, ua} * {{W{1'b0}}, ub};
      q   = ({1'b0, p} + RND) >> F;
      lim = neg ? HALF : (HALF - 1'b1);
      r   = q[W-1:0];
      if (q > lim) begin
         res = {1'b1, neg ? MINW : MAXW};
      end else begin
         res = {1'b0, neg ? (~r + 1'b1) : r};
      end
      return res;
   endfunction

   function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      logic [W:0] res;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         res = {1'b1, s[W] ? MINW : MAXW};
      end else begin
         res = {1'b0, s[W-1:0]};
      end
      return res;
   endfunction

   function automatic logic [W:0] sat_neg(input logic [W-1:0] a);
      logic [W:0] res;
      if (a == MINW) begin
         res = {1'b1, MAXW};
      end else begin
         res = {1'b0, ~a + 1'b1};
      end
      return res;
   endfunction

   function automatic logic [W:0] sum3(input logic [W-1:0] a, input logic [W-1:0] b,
                                       input logic [W-1:0] c);
      logic [W:0] r1;
      logic [W:0] r2;
      r1 = sat_add(a, b);
      r2 = sat_add(r1[W-1:0], c);
      return {r1[W] | r2[W], r2[W-1:0]};
   endfunction

   logic [W-2:0] coeff_one_ff;
   logic [W-1:0] coeff_two_ff;
   logic         adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_one_ff <= C1_RESET;
         coeff_two_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEFF_ONE: coeff_one_ff <= csr_wr_data[W-2:0];
            CSR_COEFF_TWO: coeff_two_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   cr_stage_type     cr_ff     [2*CR];
   logic [2*CR-1:0]  cr_vld_ff;
   logic [9:0]       pv_ff;

   assign adv       = !pv_ff[9] || !rsp_stall;
   assign req_stall = !adv;

   for (genvar k = 0; k < CR; k++) begin : g_root
      localparam int BIT = CR - 1 - k;
      cr_stage_type src;
      logic         src_vld;
      cr_stage_type sq_in;
      cr_stage_type cu_in;
      logic [W:0]   sq_r;
      logic [W:0]   cu_r;

      if (k == 0) begin : g_first
         assign src = '{c: '0, t: '0, sq: '0, sqsat: 1'b0, j: req_inv_jacobian,
                        b: {req_b_xz, req_b_yz, req_b_xy, req_b_zz, req_b_yy, req_b_xx}};
         assign src_vld = req_valid;
      end else begin : g_next
         assign src     = cr_ff[2*k-1];
         assign src_vld = cr_vld_ff[2*k-1];
      end

      always_comb begin
         sq_in       = src;
         sq_in.t     = src.c | ({{(W-1){1'b0}}, 1'b1} << BIT);
         sq_r        = fmul(sq_in.t, sq_in.t);
         sq_in.sq    = sq_r[W-1:0];
         sq_in.sqsat = sq_r[W];
      end

      always_comb begin
         cu_in = cr_ff[2*k];
         cu_r  = fmul(cr_ff[2*k].sq, cr_ff[2*k].t);
         if (!cr_ff[2*k].sqsat && !cu_r[W]
             && $signed(cu_r[W-1:0]) <= $signed(cr_ff[2*k].j)) begin
            cu_in.c = cr_ff[2*k].t;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cr_vld_ff[2*k]   <= 1'b0;
            cr_vld_ff[2*k+1] <= 1'b0;
         end else if (adv) begin
            cr_vld_ff[2*k]   <= src_vld;
            cr_vld_ff[2*k+1] <= cr_vld_ff[2*k];
         end
         if (adv) begin
            cr_ff[2*k]   <= sq_in;
            cr_ff[2*k+1] <= cu_in;
         end
      end
   end

   logic [W-1:0]         p1_j23_in, p1_j23_ff, p1_i1_in, p1_i1_ff, p1_j_ff;
   logic [17:0][W-1:0]   p1_prod_in, p1_prod_ff;
   logic [5:0][W-1:0]    p1_b_ff;
   logic                 p1_sat_in, p1_sat_ff;

   logic [W-1:0]         p2_j43_in, p2_j43_ff, p2_i1i1_in, p2_i1i1_ff, p2_i13_in, p2_i13_ff;
   logic [W-1:0]         p2_j23_ff, p2_j_ff;
   logic [5:0][W-1:0]    p2_b2_in, p2_b2_ff, p2_i1b_in, p2_i1b_ff, p2_b_ff;
   logic                 p2_sat_in, p2_sat_ff;

   logic [W-1:0]         p3_tr2_in, p3_tr2_ff, p3_i1sq3_in, p3_i1sq3_ff;
   logic [W-1:0]         p3_j_ff, p3_j23_ff, p3_j43_ff;
   logic [5:0][W-1:0]    p3_t1_in, p3_t1_ff, p3_t2p_in, p3_t2p_ff;
   logic                 p3_sat_in, p3_sat_ff;

   logic [W-1:0]         p4_tr23_in, p4_tr23_ff, p4_i1sq3_ff, p4_j_ff, p4_j23_ff, p4_j43_ff;
   logic [5:0][W-1:0]    p4_t1_ff, p4_t2p_ff;
   logic                 p4_sat_in, p4_sat_ff;

   logic [W-1:0]         p5_j_ff, p5_j23_ff, p5_j43_ff;
   logic [5:0][W-1:0]    p5_t1_ff, p5_t2_in, p5_t2_ff;
   logic                 p5_sat_in, p5_sat_ff;

   logic [W-1:0]         p6_j_ff;
   logic [5:0][W-1:0]    p6_di1_in, p6_di1_ff, p6_di2_in, p6_di2_ff;
   logic                 p6_sat_in, p6_sat_ff;

   logic [W-1:0]         p7_j_ff;
   logic [5:0][W-1:0]    p7_v1_in, p7_v1_ff, p7_v2_in, p7_v2_ff;
   logic                 p7_sat_in, p7_sat_ff;

   logic [W-1:0]         p8_j_ff;
   logic [5:0][W-1:0]    p8_v_in, p8_v_ff;
   logic                 p8_sat_in, p8_sat_ff;

   logic [W-1:0]         p9_j_ff;
   logic [5:0][W-1:0]    p9_w_in, p9_w_ff;
   logic                 p9_sat_in, p9_sat_ff;

   logic [5:0][W-1:0]    p10_s_in, p10_s_ff;
   logic [1:0]           p10_status_in, p10_status_ff;

   always_comb begin
      logic [W:0] r;
      logic [W:0] r2;
      r         = fmul(cr_ff[CL].c, cr_ff[CL].c);
      p1_j23_in = r[W-1:0];
      p1_sat_in = r[W];
      r         = sat_add(cr_ff[CL].b[0], cr_ff[CL].b[1]);
      r2        = sat_add(r[W-1:0], cr_ff[CL].b[2]);
      p1_i1_in  = r2[W-1:0];
      p1_sat_in = p1_sat_in | r[W] | r2[W];
      for (int m = 0; m < 18; m++) begin
         r             = fmul(cr_ff[CL].b[PA[m]], cr_ff[CL].b[PB[m]]);
         p1_prod_in[m] = r[W-1:0];
         p1_sat_in     = p1_sat_in | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      p2_sat_in  = p1_sat_ff;
      r          = fmul(p1_j23_ff, p1_j23_ff);
      p2_j43_in  = r[W-1:0];
      p2_sat_in  = p2_sat_in | r[W];
      r          = fmul(p1_i1_ff, p1_i1_ff);
      p2_i1i1_in = r[W-1:0];
      p2_sat_in  = p2_sat_in | r[W];
      r          = fmul(p1_i1_ff, THIRD);
      p2_i13_in  = r[W-1:0];
      p2_sat_in  = p2_sat_in | r[W];
      for (int m = 0; m < 6; m++) begin
         r            = sum3(p1_prod_ff[3*m], p1_prod_ff[3*m+1], p1_prod_ff[3*m+2]);
         p2_b2_in[m]  = r[W-1:0];
         p2_sat_in    = p2_sat_in | r[W];
         r            = fmul(p1_i1_ff, p1_b_ff[m]);
         p2_i1b_in[m] = r[W-1:0];
         p2_sat_in    = p2_sat_in | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      logic [W:0] n;
      p3_sat_in   = p2_sat_ff;
      r           = sum3(p2_b2_ff[0], p2_b2_ff[1], p2_b2_ff[2]);
      p3_tr2_in   = r[W-1:0];
      p3_sat_in   = p3_sat_in | r[W];
      r           = fmul(p2_i1i1_ff, THIRD);
      p3_i1sq3_in = r[W-1:0];
      p3_sat_in   = p3_sat_in | r[W];
      for (int m = 0; m < 6; m++) begin
         n         = sat_neg(p2_b_ff[m]);
         p3_sat_in = p3_sat_in | n[W];
         if (m < 3) begin
            r         = sat_add(n[W-1:0], p2_i13_ff);
            p3_sat_in = p3_sat_in | r[W];
         end else begin
            r = n;
         end
         p3_t1_in[m]  = r[W-1:0];
         n            = sat_neg(p2_i1b_ff[m]);
         r            = sat_add(p2_b2_ff[m], n[W-1:0]);
         p3_t2p_in[m] = r[W-1:0];
         p3_sat_in    = p3_sat_in | n[W] | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      r          = fmul(p3_tr2_ff, THIRD);
      p4_tr23_in = r[W-1:0];
      p4_sat_in  = p3_sat_ff | r[W];
   end

   always_comb begin
      logic [W:0] n;
      logic [W:0] r;
      logic [W:0] r2;
      p5_sat_in = p4_sat_ff;
      n         = sat_neg(p4_tr23_ff);
      p5_t2_in  = p4_t2p_ff;
      for (int m = 0; m < 3; m++) begin
         r           = sat_add(p4_t2p_ff[m], n[W-1:0]);
         r2          = sat_add(r[W-1:0], p4_i1sq3_ff);
         p5_t2_in[m] = r2[W-1:0];
         p5_sat_in   = p5_sat_in | n[W] | r[W] | r2[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      p6_sat_in = p5_sat_ff;
      for (int m = 0; m < 6; m++) begin
         r            = fmul(p5_j23_ff, p5_t1_ff[m]);
         p6_di1_in[m] = r[W-1:0];
         p6_sat_in    = p6_sat_in | r[W];
         r            = fmul(p5_j43_ff, p5_t2_ff[m]);
         p6_di2_in[m] = r[W-1:0];
         p6_sat_in    = p6_sat_in | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      p7_sat_in = p6_sat_ff;
      for (int m = 0; m < 6; m++) begin
         r           = fmul({1'b0, coeff_one_ff}, p6_di1_ff[m]);
         p7_v1_in[m] = r[W-1:0];
         p7_sat_in   = p7_sat_in | r[W];
         r           = fmul(coeff_two_ff, p6_di2_ff[m]);
         p7_v2_in[m] = r[W-1:0];
         p7_sat_in   = p7_sat_in | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      p8_sat_in = p7_sat_ff;
      for (int m = 0; m < 6; m++) begin
         r          = sat_add(p7_v1_ff[m], p7_v2_ff[m]);
         p8_v_in[m] = r[W-1:0];
         p8_sat_in  = p8_sat_in | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      p9_sat_in = p8_sat_ff;
      for (int m = 0; m < 6; m++) begin
         r          = fmul(p8_j_ff, p8_v_ff[m]);
         p9_w_in[m] = r[W-1:0];
         p9_sat_in  = p9_sat_in | r[W];
      end
   end

   always_comb begin
      logic [W:0] r;
      logic [W:0] n;
      logic       sat;
      sat = p9_sat_ff;
      for (int m = 0; m < 6; m++) begin
         r           = sat_add(p9_w_ff[m], p9_w_ff[m]);
         n           = sat_neg(r[W-1:0]);
         p10_s_in[m] = n[W-1:0];
         sat         = sat | r[W] | n[W];
      end
      if (p9_j_ff[W-1] || p9_j_ff == '0) begin
         p10_s_in      = '0;
         p10_status_in = STATUS_NONPOS;
      end else if (sat) begin
         p10_status_in = STATUS_SAT;
      end else begin
         p10_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= {pv_ff[8:0], cr_vld_ff[CL]};
      end
      if (adv) begin
         p1_j23_ff     <= p1_j23_in;
         p1_i1_ff      <= p1_i1_in;
         p1_prod_ff    <= p1_prod_in;
         p1_j_ff       <= cr_ff[CL].j;
         p1_b_ff       <= cr_ff[CL].b;
         p1_sat_ff     <= p1_sat_in;

         p2_j43_ff     <= p2_j43_in;
         p2_i1i1_ff    <= p2_i1i1_in;
         p2_i13_ff     <= p2_i13_in;
         p2_b2_ff      <= p2_b2_in;
         p2_i1b_ff     <= p2_i1b_in;
         p2_b_ff       <= p1_b_ff;
         p2_j23_ff     <= p1_j23_ff;
         p2_j_ff       <= p1_j_ff;
         p2_sat_ff     <= p2_sat_in;

         p3_tr2_ff     <= p3_tr2_in;
         p3_i1sq3_ff   <= p3_i1sq3_in;
         p3_t1_ff      <= p3_t1_in;
         p3_t2p_ff     <= p3_t2p_in;
         p3_j_ff       <= p2_j_ff;
         p3_j23_ff     <= p2_j23_ff;
         p3_j43_ff     <= p2_j43_ff;
         p3_sat_ff     <= p3_sat_in;

         p4_tr23_ff    <= p4_tr23_in;
         p4_i1sq3_ff   <= p3_i1sq3_ff;
         p4_t1_ff      <= p3_t1_ff;
         p4_t2p_ff     <= p3_t2p_ff;
         p4_j_ff       <= p3_j_ff;
         p4_j23_ff     <= p3_j23_ff;
         p4_j43_ff     <= p3_j43_ff;
         p4_sat_ff     <= p4_sat_in;

         p5_t1_ff      <= p4_t1_ff;
         p5_t2_ff      <= p5_t2_in;
         p5_j_ff       <= p4_j_ff;
         p5_j23_ff     <= p4_j23_ff;
         p5_j43_ff     <= p4_j43_ff;
         p5_sat_ff     <= p5_sat_in;

         p6_di1_ff     <= p6_di1_in;
         p6_di2_ff     <= p6_di2_in;
         p6_j_ff       <= p5_j_ff;
         p6_sat_ff     <= p6_sat_in;

         p7_v1_ff      <= p7_v1_in;
         p7_v2_ff      <= p7_v2_in;
         p7_j_ff       <= p6_j_ff;
         p7_sat_ff     <= p7_sat_in;

         p8_v_ff       <= p8_v_in;
         p8_j_ff       <= p7_j_ff;
         p8_sat_ff     <= p8_sat_in;

         p9_w_ff       <= p9_w_in;
         p9_j_ff       <= p8_j_ff;
         p9_sat_ff     <= p9_sat_in;

         p10_s_ff      <= p10_s_in;
         p10_status_ff <= p10_status_in;
      end
   end

   assign rsp_valid  = pv_ff[9];
   assign rsp_s_xx   = p10_s_ff[0];
   assign rsp_s_yy   = p10_s_ff[1];
   assign rsp_s_zz   = p10_s_ff[2];
   assign rsp_s_xy   = p10_s_ff[3];
   assign rsp_s_yz   = p10_s_ff[4];
   assign rsp_s_xz   = p10_s_ff[5];
   assign rsp_status = p10_status_ff;

endmodule

// ===== src/hds_checker.sv =====
module hds_checker
   import hds_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-1:0] rsp_s_xx,
   input logic [WORD_BITS-1:0] rsp_s_yy,
   input logic [WORD_BITS-1:0] rsp_s_zz,
   input logic [WORD_BITS-1:0] rsp_s_xy,
   input logic [WORD_BITS-1:0] rsp_s_yz,
   input logic [WORD_BITS-1:0] rsp_s_xz,
   input logic [1:0]           rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_s_xx) && $stable(rsp_status))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("req stalled while pipeline free to advance");

   a_nonpos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NONPOS |->
         rsp_s_xx == '0 && rsp_s_yy == '0 && rsp_s_zz == '0 &&
         rsp_s_xy == '0 && rsp_s_yz == '0 && rsp_s_xz == '0)
      else $error("nonzero stress for nonpositive jacobian");

endmodule

bind hyperelastic_deviatoric_stress hds_checker #(.WORD_BITS(WORD_BITS)) u_hds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_s_xx   (rsp_s_xx),
   .rsp_s_yy   (rsp_s_yy),
   .rsp_s_zz   (rsp_s_zz),
   .rsp_s_xy   (rsp_s_xy),
   .rsp_s_yz   (rsp_s_yz),
   .rsp_s_xz   (rsp_s_xz),
   .rsp_status (rsp_status)
);

// ===== bench/tb_hyperelastic_deviatoric_stress.sv =====
`timescale 1ns / 100ps

module tb_hyperelastic_deviatoric_stress
   import hds_pkg::*;
;

   localparam int WB = 32;
   localparam int FB = 20;
   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;
   localparam int LATENCY = 2 * (WB - 1) + 10;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 530;

   typedef struct {
      logic [WB-1:0] b [6];
      logic [WB-1:0] jac;
   } tensor_type;

   typedef struct {
      logic [WB-1:0] s [6];
      logic [1:0]    status;
   } stress_type;

   class stress_scoreboard;
      stress_type pending[$];
      longint  c1, c2;
      bit      sat;
      int      mismatches;
      int      checked;
      int      nonpos_seen, sat_seen_cnt;

      function new();
         c1 = 64'sd1 << FB;
         c2 = 0;
      endfunction

      function longint clip(longint v);
         if (v > MAXV) begin
            sat = 1;
            return MAXV;
         end
         if (v < MINV) begin
            sat = 1;
            return MINV;
         end
         return v;
      endfunction

      function longint add(longint a, longint b);
         return clip(a + b);
      endfunction

      function longint neg(longint a);
         return clip(-a);
      endfunction

      // round half away from zero, saturate
      function longint mul(longint a, longint b);
         logic [127:0] ua, ub, p, q;
         bit n;
         n = (a < 0) != (b < 0);
         ua = a < 0 ? 128'(-a) : 128'(a);
         ub = b < 0 ? 128'(-b) : 128'(b);
         p = ua * ub + (128'd1 << (FB - 1));
         q = p >> FB;
         if (n) begin
            if (q > 128'(64'd2147483648)) begin
               sat = 1;
               return MINV;
            end
            return -longint'(q[63:0]);
         end
         if (q > 128'(MAXV)) begin
            sat = 1;
            return MAXV;
         end
         return longint'(q[63:0]);
      endfunction

      function longint cube_root(longint j);
         longint c, t, cube;
         bit keep;
         keep = sat;
         c = 0;
         for (int i = WB - 2; i >= 0; i--) begin
            t = c | (64'sd1 << i);
            sat = 0;
            cube = mul(mul(t, t), t);
            if (!sat && cube <= j) c = t;
         end
         sat = keep;
         return c;
      endfunction

      function void write_coeff(logic idx, logic [WB-1:0] v);
         if (idx == CSR_COEFF_ONE) c1 = longint'({1'b0, v[WB-2:0]});
         else c2 = longint'(signed'(v));
      endfunction

      function void note_tensor(tensor_type t);
         stress_type r;
         longint b[6], b2[6], s[6], j, i1, tr2, third, i1_3, tr2_3, i1sq_3, j23, j43;
         longint t1, t2, d1, d2, v;
         for (int k = 0; k < 6; k++) b[k] = longint'(signed'(t.b[k]));
         j = longint'(signed'(t.jac));
         sat = 0;
         if (j <= 0) begin
            for (int k = 0; k < 6; k++) r.s[k] = '0;
            r.status = STATUS_NONPOS;
            pending.push_back(r);
            return;
         end
         i1 = add(add(b[0], b[1]), b[2]);
         b2[0] = add(add(mul(b[0], b[0]), mul(b[3], b[3])), mul(b[5], b[5]));
         b2[1] = add(add(mul(b[3], b[3]), mul(b[1], b[1])), mul(b[4], b[4]));
         b2[2] = add(add(mul(b[5], b[5]), mul(b[4], b[4])), mul(b[2], b[2]));
         b2[3] = add(add(mul(b[0], b[3]), mul(b[3], b[1])), mul(b[5], b[4]));
         b2[4] = add(add(mul(b[3], b[5]), mul(b[1], b[4])), mul(b[4], b[2]));
         b2[5] = add(add(mul(b[0], b[5]), mul(b[3], b[4])), mul(b[5], b[2]));
         tr2 = add(add(b2[0], b2[1]), b2[2]);
         third = ((64'sd1 << FB) + 1) / 3;
         i1_3 = mul(i1, third);
         tr2_3 = mul(tr2, third);
         i1sq_3 = mul(mul(i1, i1), third);
         j23 = cube_root(j);
         j23 = mul(j23, j23);
         j43 = mul(j23, j23);
         for (int k = 0; k < 6; k++) begin
            t1 = neg(b[k]);
            t2 = add(b2[k], neg(mul(i1, b[k])));
            if (k < 3) begin
               t1 = add(t1, i1_3);
               t2 = add(add(t2, neg(tr2_3)), i1sq_3);
            end
            d1 = mul(j23, t1);
            d2 = mul(j43, t2);
            v = mul(j, add(mul(c1, d1), mul(c2, d2)));
            s[k] = neg(add(v, v));
         end
         for (int k = 0; k < 6; k++) r.s[k] = s[k][WB-1:0];
         r.status = sat ? STATUS_SAT : STATUS_OK;
         pending.push_back(r);
      endfunction

      function void check_stress(stress_type got);
         stress_type e;
         bit bad;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat at %0t", $time);
            return;
         end
         e = pending.pop_front();
         if (e.status == STATUS_NONPOS) nonpos_seen++;
         if (e.status == STATUS_SAT) sat_seen_cnt++;
         bad = (e.status != got.status);
         for (int k = 0; k < 6; k++) if (e.s[k] !== got.s[k]) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %0t: exp %h %h %h %h %h %h st %0d got %h %h %h %h %h %h st %0d",
                  $time, e.s[0], e.s[1], e.s[2], e.s[3], e.s[4], e.s[5], e.status,
                  got.s[0], got.s[1], got.s[2], got.s[3], got.s[4], got.s[5], got.status);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [WB-1:0] req_b_xx = 0, req_b_yy = 0, req_b_zz = 0;
   logic [WB-1:0] req_b_xy = 0, req_b_yz = 0, req_b_xz = 0, req_inv_jacobian = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [WB-1:0] rsp_s_xx, rsp_s_yy, rsp_s_zz, rsp_s_xy, rsp_s_yz, rsp_s_xz;
   logic [1:0] rsp_status;
   logic csr_wr_en = 0, csr_index = 0;
   logic [WB-1:0] csr_wr_data = 0;

   stress_scoreboard board = new();
   tensor_type beats[$];
   int idle_cnt;
   bit quiet;
   bit hold_off;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   hyperelastic_deviatoric_stress dut (.*);

   always @(posedge clock) begin
      stress_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.s[0] = rsp_s_xx; got.s[1] = rsp_s_yy; got.s[2] = rsp_s_zz;
         got.s[3] = rsp_s_xy; got.s[4] = rsp_s_yz; got.s[5] = rsp_s_xz;
         got.status = rsp_status;
         board.check_stress(got);
      end
      if (!reset && req_valid && !req_stall) board.note_tensor(beats.pop_front());
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG) begin
         $display("watchdog expired");
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= !quiet && ($urandom_range(99) < 12);
   end

   task automatic send(tensor_type t);
      beats.push_back(t);
      while (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_b_xx <= t.b[0]; req_b_yy <= t.b[1]; req_b_zz <= t.b[2];
      req_b_xy <= t.b[3]; req_b_yz <= t.b[4]; req_b_xz <= t.b[5];
      req_inv_jacobian <= t.jac;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_coeff(logic idx, logic [WB-1:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= v;
      board.write_coeff(idx, v);
      @(negedge clock);
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   function automatic logic [WB-1:0] rand_val(int mode);
      case (mode)
         0: return $urandom();
         1: return WB'(signed'(int'($urandom_range(4 << FB)) - (2 << FB)));
         2: return WB'(signed'(int'($urandom_range(1 << 18)) - (1 << 17)));
         default: return (1 << FB) + $urandom_range(1 << 17) - (1 << 16);
      endcase
   endfunction

   function automatic tensor_type rand_tensor();
      tensor_type t;
      int m;
      m = $urandom_range(9);
      for (int k = 0; k < 6; k++)
         t.b[k] = (m == 0) ? rand_val(0) : rand_val(k < 3 ? 3 : 2 - (m & 1));
      case ($urandom_range(9))
         0: t.jac = $urandom();
         1: t.jac = -$urandom_range(1 << 24);
         2: t.jac = 0;
         default: t.jac = $urandom_range(3 << FB, 1 << 16);
      endcase
      return t;
   endfunction

   function automatic tensor_type same(logic [WB-1:0] v, logic [WB-1:0] j);
      tensor_type t;
      for (int k = 0; k < 6; k++) t.b[k] = v;
      t.jac = j;
      return t;
   endfunction

   task automatic directed();
      tensor_type t;
      send(same(32'h0010_0000, 32'h0010_0000));
      send(same(32'h0010_0000, 32'h0000_0000));
      send(same(32'h0010_0000, 32'h8000_0000));
      send(same(32'h0010_0000, 32'hffff_ffff));
      send(same(32'h7fff_ffff, 32'h7fff_ffff));
      send(same(32'h8000_0000, 32'h0000_0001));
      send(same(32'h0000_0000, 32'h0010_0000));
      send(same(32'hffff_ffff, 32'h0008_0000));
      send(same(32'h5555_5555, 32'haaaa_aaaa));
      send(same(32'haaaa_aaaa, 32'h5555_5555));
      for (int k = 0; k < 6; k++) begin
         t = same(0, 32'h0020_0000);
         t.b[k] = 32'h8000_0000;
         send(t);
      end
      t = same(0, 32'h0010_0000);
      t.b[0] = 32'h0018_0000; t.b[1] = 32'h000c_0000; t.b[2] = 32'h0010_0000;
      t.b[3] = 32'h0001_0000; t.b[4] = 32'hffff_0000; t.b[5] = 32'h0002_0000;
      send(t);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_coeff(CSR_COEFF_TWO, 32'h0008_0000);
      directed();
      drain();
      write_coeff(CSR_COEFF_ONE, 32'h7fff_ffff);
      write_coeff(CSR_COEFF_TWO, 32'h8000_0000);
      directed();
      drain();
      write_coeff(CSR_COEFF_ONE, 32'h0000_0001);
      write_coeff(CSR_COEFF_TWO, 32'h7fff_ffff);
      for (int i = 0; i < 40; i++) send(rand_tensor());
      drain();
      write_coeff(CSR_COEFF_ONE, 32'h0000_0000);
      write_coeff(CSR_COEFF_TWO, 32'hffff_ffff);
      for (int i = 0; i < 30; i++) send(rand_tensor());
      drain();
      // hold off the receiver so the pipeline fills
      fork
         begin
            hold_off = 1;
            repeat (LATENCY * 2) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 120; i++) send(rand_tensor());
      join
      drain();
      for (int p = 0; p < 4; p++) begin
         write_coeff(CSR_COEFF_ONE, $urandom_range(32'h7fff_ffff, 1));
         write_coeff(CSR_COEFF_TWO, rand_val(p == 0 ? 0 : 1));
         quiet = (p == 2);
         for (int i = 0; i < (N_RANDOM - 190) / 4; i++) send(rand_tensor());
         quiet = 0;
         drain();
      end
      $display("checked %0d stress beats (%0d nonpositive j, %0d saturated)",
         board.checked, board.nonpos_seen, board.sat_seen_cnt);
      $display("coefficients swept over extremes and random values; backpressure applied");
      if (board.mismatches == 0 && board.pending.size() == 0) $display("PASS");
      else begin
         $display("%0d mismatches, %0d left over", board.mismatches, board.pending.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/hds_pkg.sv
src/hyperelastic_deviatoric_stress.sv
src/hds_checker.sv
bench/tb_hyperelastic_deviatoric_stress.sv
